>>> sv/assert_macros.svh
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check, clocked, held off during reset.
`define ATL_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Same-cycle implication check.
`define ATL_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication check.
`define ATL_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> sv/atl_pkg.sv
`default_nettype none

package atl_pkg;

    localparam int MAX_LINE_DEF = 256;

    // parser modes; error modes are MODE_ERR_BASE + error code
    localparam logic [3:0] MODE_START     = 4'd0;
    localparam logic [3:0] MODE_PRED      = 4'd1;
    localparam logic [3:0] MODE_SKIP_NAME = 4'd2;
    localparam logic [3:0] MODE_NAME      = 4'd3;
    localparam logic [3:0] MODE_SKIP_MOD  = 4'd4;
    localparam logic [3:0] MODE_MOD       = 4'd5;
    localparam logic [3:0] MODE_OPER      = 4'd6;
    localparam logic [3:0] MODE_SKIP_OPER = 4'd7;
    localparam logic [3:0] MODE_ERR_BASE  = 4'd8;
    localparam logic [3:0] MODE_ERR_LAST  = 4'd12;

    localparam logic [2:0] KIND_NONE = 3'd0;
    localparam logic [2:0] KIND_PRED = 3'd1;
    localparam logic [2:0] KIND_NAME = 3'd2;
    localparam logic [2:0] KIND_MOD  = 3'd3;
    localparam logic [2:0] KIND_OPER = 3'd4;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_EMPTY_NAM = 3'd1;
    localparam logic [2:0] ERR_EMPTY_MOD = 3'd2;
    localparam logic [2:0] ERR_EMPTY_OPR = 3'd3;
    localparam logic [2:0] ERR_OVERFLOW  = 3'd4;

    localparam logic [7:0] CHAR_NONBLANK = 8'd33;  // first non-blank byte
    localparam logic [7:0] CHAR_AT       = 8'h40;
    localparam logic [7:0] CHAR_COMMA    = 8'h2C;
    localparam logic [7:0] CHAR_DOT      = 8'h2E;

    localparam int START_W = 8;
    localparam int LEN_W   = 9;

    typedef struct packed {
        logic [2:0]         kind;
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   length;
        logic [2:0]         err;
        logic               done;
        logic               pred;
    } t_result;

endpackage

`default_nettype wire

>>> sv/assembly_line_tokenizer_unit.sv
// A result passes through the input register, then the result register.
// Throughput: 1 item per cycle while no result is stalled; the parser state loops through the combinational step.
// An item with no result still passes the input register; a stalled result holds the line.
// Reset (i_rst_n low, synchronous): parser at line start, positions 0, no predicate,
// input and result registers empty.
`default_nettype none

module assembly_line_tokenizer_unit
    import atl_pkg::*;
#(
    parameter int MAX_LINE = MAX_LINE_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // input channel
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic       i_in_op,
    input  wire logic [7:0] i_in_char_code,
    // result channel
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [2:0]      o_out_token_kind,
    output logic [7:0]      o_out_token_start,
    output logic [8:0]      o_out_token_length,
    output logic [2:0]      o_out_error_code,
    output logic            o_out_line_done,
    output logic            o_out_predicated
);

    // position counter saturates at MAX_LINE
    localparam int POS_W = $clog2(MAX_LINE + 1);

    // input register
    logic       r_in_valid;
    logic       r_in_op;
    logic [7:0] r_in_char;

    // parser state
    logic [3:0]       r_mode;
    logic [POS_W-1:0] r_begin;
    logic [POS_W-1:0] r_pos;
    logic             r_has_pred;

    logic [3:0]       n_mode;
    logic [POS_W-1:0] n_begin;
    logic [POS_W-1:0] n_pos;
    logic             n_has_pred;

    logic    step_emit;
    t_result step_res;
    t_result out_res;
    logic    out_free;
    logic    proc_go;
    logic    in_take;

    // the held item steps the parser once the result register can take a result
    assign proc_go    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (proc_go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_op   <= i_in_op;
            r_in_char <= i_in_char_code;
        end
    end

    atl_step #(
        .MAX_LINE (MAX_LINE),
        .POS_W    (POS_W)
    ) u_step (
        .i_mode     (r_mode),
        .i_begin    (r_begin),
        .i_pos      (r_pos),
        .i_has_pred (r_has_pred),
        .i_op       (r_in_op),
        .i_char     (r_in_char),
        .o_mode     (n_mode),
        .o_begin    (n_begin),
        .o_pos      (n_pos),
        .o_has_pred (n_has_pred),
        .o_emit     (step_emit),
        .o_res      (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_START;
            r_begin    <= '0;
            r_pos      <= '0;
            r_has_pred <= 1'b0;
        end else if (proc_go) begin
            r_mode     <= n_mode;
            r_begin    <= n_begin;
            r_pos      <= n_pos;
            r_has_pred <= n_has_pred;
        end
    end

    atl_result_reg u_result (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (proc_go && step_emit),
        .i_res   (step_res),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_free  (out_free),
        .o_res   (out_res)
    );

    assign o_out_token_kind   = out_res.kind;
    assign o_out_token_start  = out_res.start;
    assign o_out_token_length = out_res.length;
    assign o_out_error_code   = out_res.err;
    assign o_out_line_done    = out_res.done;
    assign o_out_predicated   = out_res.pred;

endmodule

`default_nettype wire

>>> sv/atl_step.sv
`default_nettype none

// One parser step: next state and optional result for one item.
module atl_step
    import atl_pkg::*;
#(
    parameter int MAX_LINE = MAX_LINE_DEF,
    parameter int POS_W    = $clog2(MAX_LINE + 1)
) (
    input  wire logic [3:0]       i_mode,
    input  wire logic [POS_W-1:0] i_begin,
    input  wire logic [POS_W-1:0] i_pos,
    input  wire logic             i_has_pred,
    input  wire logic             i_op,
    input  wire logic [7:0]       i_char,
    output logic [3:0]            o_mode,
    output logic [POS_W-1:0]      o_begin,
    output logic [POS_W-1:0]      o_pos,
    output logic                  o_has_pred,
    output logic                  o_emit,
    output t_result               o_res
);

    localparam int EXT_W = (POS_W > LEN_W) ? POS_W : LEN_W;
    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_LINE);

    logic             blank;
    logic [EXT_W-1:0] begin_ext;
    logic [EXT_W-1:0] diff_ext;
    logic [START_W-1:0] tok_start;
    logic [LEN_W-1:0]   tok_len;
    logic [POS_W-1:0]   pos_inc;

    assign blank     = i_char < CHAR_NONBLANK;
    assign begin_ext = EXT_W'(i_begin);
    assign diff_ext  = EXT_W'(i_pos) - begin_ext;
    assign tok_start = begin_ext[START_W-1:0];
    assign tok_len   = diff_ext[LEN_W-1:0];
    assign pos_inc   = i_pos + POS_W'(1);

    always_comb begin
        o_mode     = i_mode;
        o_begin    = i_begin;
        o_pos      = i_pos;
        o_has_pred = i_has_pred;
        o_emit     = 1'b0;
        o_res      = '0;

        if (i_op) begin
            // end of line: close any open token, report, return to line start
            o_emit          = 1'b1;
            o_res.done      = 1'b1;
            o_res.pred      = i_has_pred;
            unique case (i_mode)
                MODE_PRED: o_res.kind = KIND_PRED;
                MODE_NAME: o_res.kind = KIND_NAME;
                MODE_OPER: o_res.kind = KIND_OPER;
                MODE_MOD: begin
                    if (i_pos == i_begin) o_res.err  = ERR_EMPTY_MOD;
                    else                  o_res.kind = KIND_MOD;
                end
                default: begin
                    if (i_mode > MODE_ERR_BASE && i_mode <= MODE_ERR_LAST)
                        o_res.err = 3'(i_mode - MODE_ERR_BASE);
                end
            endcase
            if (o_res.kind != KIND_NONE) begin
                o_res.start  = tok_start;
                o_res.length = tok_len;
            end
            o_mode     = MODE_START;
            o_begin    = '0;
            o_pos      = '0;
            o_has_pred = 1'b0;
        end else if (i_mode >= MODE_ERR_BASE) begin
            // rest of line ignored, position still counts up to the limit
            if (i_pos < MAX_POS) o_pos = pos_inc;
        end else if (i_pos >= MAX_POS) begin
            o_mode    = MODE_ERR_BASE + 4'(ERR_OVERFLOW);
            o_emit    = 1'b1;
            o_res.err = ERR_OVERFLOW;
        end else begin
            o_pos = pos_inc;
            unique case (i_mode)
                MODE_START, MODE_SKIP_NAME: begin
                    if (i_mode == MODE_START && i_char == CHAR_AT) begin
                        o_has_pred = 1'b1;
                        o_begin    = '0;
                        o_mode     = MODE_PRED;
                    end else begin
                        o_mode = MODE_SKIP_NAME;
                        if (!blank) begin
                            o_begin = i_pos;
                            if (i_char == CHAR_DOT) begin
                                o_mode    = MODE_ERR_BASE + 4'(ERR_EMPTY_NAM);
                                o_emit    = 1'b1;
                                o_res.err = ERR_EMPTY_NAM;
                            end else begin
                                o_mode = MODE_NAME;
                            end
                        end
                    end
                end
                MODE_PRED: begin
                    if (blank) begin
                        o_mode       = MODE_SKIP_NAME;
                        o_emit       = 1'b1;
                        o_res.kind   = KIND_PRED;
                        o_res.start  = tok_start;
                        o_res.length = tok_len;
                    end
                end
                MODE_NAME: begin
                    if (blank || i_char == CHAR_DOT) begin
                        o_emit       = 1'b1;
                        o_res.kind   = KIND_NAME;
                        o_res.start  = tok_start;
                        o_res.length = tok_len;
                        if (blank) begin
                            o_mode = MODE_SKIP_MOD;
                        end else begin
                            o_mode  = MODE_MOD;
                            o_begin = pos_inc;
                        end
                    end
                end
                MODE_SKIP_MOD, MODE_SKIP_OPER: begin
                    if (!blank) begin
                        if (i_mode == MODE_SKIP_MOD && i_char == CHAR_DOT) begin
                            o_mode  = MODE_MOD;
                            o_begin = pos_inc;
                        end else begin
                            // first operand character
                            o_begin = i_pos;
                            if (i_char == CHAR_COMMA) begin
                                o_mode    = MODE_ERR_BASE + 4'(ERR_EMPTY_OPR);
                                o_emit    = 1'b1;
                                o_res.err = ERR_EMPTY_OPR;
                            end else begin
                                o_mode = MODE_OPER;
                            end
                        end
                    end
                end
                MODE_MOD: begin
                    if (blank || i_char == CHAR_DOT) begin
                        o_emit = 1'b1;
                        if (i_pos == i_begin) begin
                            o_mode    = MODE_ERR_BASE + 4'(ERR_EMPTY_MOD);
                            o_res.err = ERR_EMPTY_MOD;
                        end else begin
                            o_res.kind   = KIND_MOD;
                            o_res.start  = tok_start;
                            o_res.length = tok_len;
                            if (blank) o_mode  = MODE_SKIP_MOD;
                            else       o_begin = pos_inc;
                        end
                    end
                end
                MODE_OPER: begin
                    if (i_char == CHAR_COMMA) begin
                        o_mode       = MODE_SKIP_OPER;
                        o_emit       = 1'b1;
                        o_res.kind   = KIND_OPER;
                        o_res.start  = tok_start;
                        o_res.length = tok_len;
                    end
                end
                default: o_mode = MODE_START;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> sv/atl_result_reg.sv
`default_nettype none

// Output register: holds one result until the consumer takes it.
module atl_result_reg
    import atl_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_result i_res,
    input  wire logic    i_stall,
    output logic         o_valid,
    output logic         o_free,
    output t_result      o_res
);

    logic    r_valid;
    t_result r_res;

    assign o_free  = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

`default_nettype wire

>>> sv/atl_checker.sv
`default_nettype none

`include "assert_macros.svh"

module atl_checker
    import atl_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_stall,
    input wire logic       i_in_op,
    input wire logic [7:0] i_in_char_code,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic [2:0] o_out_token_kind,
    input wire logic [7:0] o_out_token_start,
    input wire logic [8:0] o_out_token_length,
    input wire logic [2:0] o_out_error_code,
    input wire logic       o_out_line_done,
    input wire logic       o_out_predicated
);

    `ATL_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_token_kind) && $stable(o_out_token_length) && $stable(o_out_error_code) && $stable(o_out_line_done))
    `ATL_ASSERT_IMPL(a_pred_only_done, i_clk, i_rst_n, o_out_valid && !o_out_line_done, !o_out_predicated)
    `ATL_ASSERT_IMPL(a_none_zero, i_clk, i_rst_n, o_out_valid && o_out_token_kind == KIND_NONE, o_out_token_start == 8'd0 && o_out_token_length == 9'd0)
    `ATL_ASSERT_IMPL(a_err_no_token, i_clk, i_rst_n, o_out_valid && o_out_error_code != ERR_NONE, o_out_token_kind == KIND_NONE)
    `ATL_ASSERT_IMPL(a_pred_at_zero, i_clk, i_rst_n, o_out_valid && o_out_token_kind == KIND_PRED, o_out_token_start == 8'd0)

endmodule

bind assembly_line_tokenizer_unit atl_checker u_atl_checker (.*);

`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
    import atl_pkg::*;

    localparam int MAX_LINE     = MAX_LINE_DEF;
    localparam int RANDOM_ITEMS = 970;
    localparam int HOLD_CYCLES  = 200;      // long receiver hold-off
    localparam int SETTLE       = 10;       // well past the result latency
    localparam int CYCLE_LIMIT  = 400000;

    // item opcodes on i_in_op
    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_EOL  = 1'b1;

    localparam logic [7:0] CHAR_SPACE = 8'd32;

    logic       i_clk          = 1'b0;
    logic       i_rst_n        = 1'b0;
    logic       i_in_valid     = 1'b0;
    logic       i_in_op        = OP_CHAR;
    logic [7:0] i_in_char_code = 8'd0;
    logic       i_out_stall    = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [2:0] o_out_token_kind;
    logic [7:0] o_out_token_start;
    logic [8:0] o_out_token_length;
    logic [2:0] o_out_error_code;
    logic       o_out_line_done;
    logic       o_out_predicated;

    assembly_line_tokenizer_unit #(
        .MAX_LINE(MAX_LINE)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_in_op           (i_in_op),
        .i_in_char_code    (i_in_char_code),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_out_token_kind  (o_out_token_kind),
        .o_out_token_start (o_out_token_start),
        .o_out_token_length(o_out_token_length),
        .o_out_error_code  (o_out_error_code),
        .o_out_line_done   (o_out_line_done),
        .o_out_predicated  (o_out_predicated)
    );

    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Tokenizer prediction state: parser mode, start of the open token,
    // next character position on the line, and the line's predicate flag.
    // Positions are kept wide; only the reported start wraps at 256.
    // ------------------------------------------------------------------
    logic [3:0] tk_mode  = MODE_START;
    int         tk_begin = 0;
    int         tk_pos   = 0;
    bit         tk_pred  = 1'b0;

    t_result    token_q[$];     // expected results, oldest first
    logic [7:0] text_q[$];      // bytes of the line being built
    int         fail_cnt = 0;
    int         cycle_cnt = 0;

    // sender burst control
    bit sender_idle = 1'b1;
    int burst_left  = 0;

    // receiver hold-off requests, served in the receiver's own process
    int hold_asks = 0;
    int hold_done = 0;
    int hold_left = 0;
    logic [15:0] stall_pat = 16'h0;
    int pat_left = 0;

    // Append one expected result.
    function automatic void expect_add(input t_result r);
        token_q = {token_q, r};
    endfunction

    // Append one byte to the line being built.
    function automatic void text_add(input logic [7:0] c);
        text_q = {text_q, c};
    endfunction

    // Close the open token at pos.
    function automatic bit close_token(input logic [2:0] kind, input int pos,
                                       output t_result r);
        r        = '0;
        r.kind   = kind;
        r.start  = tk_begin[7:0];
        r.length = 9'(pos - tk_begin);
        return 1'b1;
    endfunction

    // Enter an error mode; the rest of the line is swallowed.
    function automatic bit line_error(input logic [2:0] code, output t_result r);
        tk_mode = 4'(MODE_ERR_BASE + code);
        r       = '0;
        r.err   = code;
        return 1'b1;
    endfunction

    // First non-blank where an operand should begin; a comma means empty operand.
    function automatic bit open_operand(input logic [7:0] ch, input int pos,
                                        output t_result r);
        tk_begin = pos;
        if (ch == CHAR_COMMA) return line_error(ERR_EMPTY_OPR, r);
        tk_mode = MODE_OPER;
        r = '0;
        return 1'b0;
    endfunction

    // Advance the tokenizer by one item; returns 1 when a result is due.
    function automatic bit tokenize_byte(input logic op, input logic [7:0] ch,
                                         output t_result r);
        int pos;
        bit blank;
        pos   = tk_pos;
        blank = (ch < CHAR_NONBLANK);
        r     = '0;

        if (op == OP_EOL) begin
            // end of line: report whatever token is still open, or the error
            r.done = 1'b1;
            r.pred = tk_pred;
            case (tk_mode)
                MODE_PRED: r.kind = KIND_PRED;
                MODE_NAME: r.kind = KIND_NAME;
                MODE_OPER: r.kind = KIND_OPER;
                MODE_MOD: begin
                    if (pos == tk_begin) r.err = ERR_EMPTY_MOD;
                    else r.kind = KIND_MOD;
                end
                default: begin
                    if (tk_mode > MODE_ERR_BASE && tk_mode <= MODE_ERR_LAST)
                        r.err = 3'(tk_mode - MODE_ERR_BASE);
                end
            endcase
            if (r.kind != KIND_NONE) begin
                r.start  = tk_begin[7:0];
                r.length = 9'(pos - tk_begin);
            end
            tk_mode  = MODE_START;
            tk_begin = 0;
            tk_pos   = 0;
            tk_pred  = 1'b0;
            return 1'b1;
        end

        if (tk_mode >= MODE_ERR_BASE) begin
            if (tk_pos < MAX_LINE) tk_pos++;
            return 1'b0;
        end
        if (pos >= MAX_LINE) return line_error(ERR_OVERFLOW, r);
        tk_pos = pos + 1;

        case (tk_mode)
            MODE_START, MODE_SKIP_NAME: begin
                // '@' only opens a predicate at the very first position
                if (tk_mode == MODE_START && ch == CHAR_AT) begin
                    tk_pred  = 1'b1;
                    tk_begin = 0;
                    tk_mode  = MODE_PRED;
                    return 1'b0;
                end
                tk_mode = MODE_SKIP_NAME;
                if (blank) return 1'b0;
                tk_begin = pos;
                if (ch == CHAR_DOT) return line_error(ERR_EMPTY_NAM, r);
                tk_mode = MODE_NAME;
                return 1'b0;
            end
            MODE_PRED: begin
                if (!blank) return 1'b0;
                tk_mode = MODE_SKIP_NAME;
                return close_token(KIND_PRED, pos, r);
            end
            MODE_NAME: begin
                if (blank) begin
                    tk_mode = MODE_SKIP_MOD;
                    return close_token(KIND_NAME, pos, r);
                end
                if (ch == CHAR_DOT) begin
                    void'(close_token(KIND_NAME, pos, r));
                    tk_mode  = MODE_MOD;
                    tk_begin = pos + 1;
                    return 1'b1;
                end
                return 1'b0;
            end
            MODE_SKIP_MOD: begin
                if (blank) return 1'b0;
                if (ch == CHAR_DOT) begin
                    tk_mode  = MODE_MOD;
                    tk_begin = pos + 1;
                    return 1'b0;
                end
                return open_operand(ch, pos, r);
            end
            MODE_MOD: begin
                if (blank || ch == CHAR_DOT) begin
                    if (pos == tk_begin) return line_error(ERR_EMPTY_MOD, r);
                    void'(close_token(KIND_MOD, pos, r));
                    if (blank) tk_mode = MODE_SKIP_MOD;
                    else tk_begin = pos + 1;
                    return 1'b1;
                end
                return 1'b0;
            end
            MODE_OPER: begin
                if (ch == CHAR_COMMA) begin
                    tk_mode = MODE_SKIP_OPER;
                    return close_token(KIND_OPER, pos, r);
                end
                return 1'b0;
            end
            MODE_SKIP_OPER: begin
                if (blank) return 1'b0;
                return open_operand(ch, pos, r);
            end
            default: tk_mode = MODE_START;
        endcase
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Character pickers
    // ------------------------------------------------------------------
    function automatic logic [7:0] pick_blank();
        if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 31));
        return CHAR_SPACE;
    endfunction

    // non-blank, neither '.' nor ','
    function automatic logic [7:0] pick_word();
        logic [7:0] c;
        do c = 8'($urandom_range(33, 255)); while (c == CHAR_DOT || c == CHAR_COMMA);
        return c;
    endfunction

    // anything, biased toward the characters the parser cares about
    function automatic logic [7:0] pick_any();
        case ($urandom_range(0, 9))
            0, 1, 2: return pick_blank();
            3:       return CHAR_DOT;
            4:       return CHAR_COMMA;
            5:       return CHAR_AT;
            default: return pick_word();
        endcase
    endfunction

    // operand body: words, inner blanks and dots, never a comma
    function automatic logic [7:0] pick_operand_char();
        case ($urandom_range(0, 5))
            0:       return pick_blank();
            1:       return CHAR_DOT;
            default: return pick_word();
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Sender: one item per call, bursts of random length with random gaps between while sender_idle is set.
    // Valid stays high across a burst; it is only lowered for a gap or a drain.
    // ------------------------------------------------------------------
    task automatic send_item(input logic op, input logic [7:0] ch);
        int gap;
        t_result res;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = sender_idle ? $urandom_range(0, 6) : 0;
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid     <= 1'b1;
        i_in_op        <= op;
        i_in_char_code <= ch;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (tokenize_byte(op, ch, res)) expect_add(res);
    endtask

    task automatic send_eol();
        send_item(OP_EOL, 8'($urandom));   // char byte is a don't-care here
    endtask

    task automatic send_str(input string s);
        foreach (s[i]) send_item(OP_CHAR, s[i]);
    endtask

    task automatic send_run(input logic [7:0] ch, input int n);
        repeat (n) send_item(OP_CHAR, ch);
    endtask

    // Stop offering items and wait until every expected result has arrived.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (token_q.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    // Build one line into text_q. Mostly well-formed lines with random content;
    // some get a byte corrupted, some are pure noise, a few run past MAX_LINE.
    task automatic build_line();
        int n;
        int target;
        text_q.delete();
        if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(0, 20);
            repeat (n) text_add(pick_any());
            return;
        end
        if ($urandom_range(0, 3) == 0) begin
            text_add(CHAR_AT);
            repeat ($urandom_range(0, 4)) text_add(pick_word());
            repeat ($urandom_range(1, 3)) text_add(pick_blank());
        end else begin
            repeat ($urandom_range(0, 2)) text_add(pick_blank());
        end
        // instruction name, then modifiers
        repeat ($urandom_range(1, 6)) text_add(pick_word());
        repeat ($urandom_range(0, 3)) begin
            if ($urandom_range(0, 3) == 0) text_add(pick_blank());
            text_add(CHAR_DOT);
            repeat ($urandom_range(1, 4)) text_add(pick_word());
        end
        // operands, comma separated
        n = $urandom_range(0, 4);
        if (n != 0) repeat ($urandom_range(1, 2)) text_add(pick_blank());
        for (int k = 0; k < n; k++) begin
            if (k != 0) begin
                text_add(CHAR_COMMA);
                repeat ($urandom_range(0, 2)) text_add(pick_blank());
            end
            text_add(pick_word());
            repeat ($urandom_range(0, 6)) text_add(pick_operand_char());
        end
        if (n != 0 && $urandom_range(0, 4) == 0) begin
            text_add(CHAR_COMMA);
            repeat ($urandom_range(0, 2)) text_add(pick_blank());
        end
        // rare overlong line
        if ($urandom_range(0, 49) == 0) begin
            target = $urandom_range(MAX_LINE - 6, MAX_LINE + 8);
            while (text_q.size() < target) text_add(pick_operand_char());
        end
        // broken line: one byte replaced by something arbitrary
        if (text_q.size() != 0 && $urandom_range(0, 5) == 0)
            text_q[$urandom_range(0, text_q.size() - 1)] = pick_any();
    endtask

    task automatic send_built_line();
        foreach (text_q[i]) send_item(OP_CHAR, text_q[i]);
        send_eol();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hand-picked lines: empty line, name starting with '.', predicate
    // followed by an empty modifier, comma where an operand should start,
    // name/modifier/operand with blank 0 and byte 0xFF plus trailing comma,
    // and a name closed by end of line.
    task automatic test_directed_cases();
        sender_idle = 1'b1;
        send_eol();
        send_str(".x");
        send_eol();
        send_str("@ a..");
        send_eol();
        send_str("b ,");
        send_eol();
        send_str("c.d");
        send_item(OP_CHAR, 8'h00);
        send_item(OP_CHAR, 8'hFF);
        send_str(", ");
        send_eol();
        send_str("e");
        send_eol();
        drain_results();
    endtask

    // Lines at and past MAX_LINE.
    task automatic test_long_lines();
        sender_idle = 1'b0;
        // exactly MAX_LINE characters: operand closed by end of line
        send_str("n ");
        send_run("x", MAX_LINE - 2);
        send_eol();
        // '.' on the last legal position: modifier would start at MAX_LINE
        send_run("a", MAX_LINE - 1);
        send_item(OP_CHAR, CHAR_DOT);
        send_eol();
        // one character too many, then more that must be ignored
        sender_idle = 1'b1;
        send_run("a", MAX_LINE - 1);
        send_item(OP_CHAR, CHAR_DOT);
        send_run("b", 4);
        send_eol();
        drain_results();
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering,
    // so the pipeline fills and stalls its input; then the sender pauses.
    task automatic test_backpressure();
        sender_idle = 1'b0;
        hold_asks++;
        repeat (4) begin
            build_line();
            send_built_line();
        end
        drain_results();
    endtask

    task automatic test_random_lines();
        int sent;
        int lines;
        sent  = 0;
        lines = 0;
        while (sent < RANDOM_ITEMS) begin
            build_line();
            sender_idle = ($urandom_range(0, 4) != 0);
            if (lines % 40 == 20) begin
                sender_idle = 1'b0;
                hold_asks++;
            end
            send_built_line();
            sent += text_q.size() + 1;
            lines++;
            if (lines % 25 == 0) drain_results();
        end
        drain_results();
    endtask

    // ------------------------------------------------------------------
    // Receiver stall: random 16-bit stall patterns, sometimes clear, sometimes heavy,
    // overridden by a counted hold-off when a test asks for one.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_asks != hold_done) begin
            hold_done   <= hold_asks;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (pat_left == 0) begin
            case ($urandom_range(0, 3))
                0:       stall_pat <= 16'h0;
                1:       stall_pat <= 16'($urandom);
                2:       stall_pat <= 16'($urandom & $urandom);
                default: stall_pat <= 16'($urandom | $urandom);
            endcase
            pat_left    <= 16;
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= stall_pat[0];
            stall_pat   <= stall_pat >> 1;
            pat_left    <= pat_left - 1;
        end
    end

    // ------------------------------------------------------------------
    // Result checker: every accepted result against the oldest expectation.
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            fail_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (token_q.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, got kind %0d start %0d",
                         $time, o_out_token_kind, o_out_token_start);
                fail_cnt++;
            end else begin
                want = token_q.pop_front();
                check_field("token_kind",   want.kind,   o_out_token_kind);
                check_field("token_start",  want.start,  o_out_token_start);
                check_field("token_length", want.length, o_out_token_length);
                check_field("error_code",   want.err,    o_out_error_code);
                check_field("line_done",    want.done,   o_out_line_done);
                check_field("predicated",   want.pred,   o_out_predicated);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_long_lines();
        test_backpressure();
        test_random_lines();

        drain_results();
        repeat (SETTLE) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> assembly_line_tokenizer_unit.f
+incdir+sv
sv/atl_pkg.sv
sv/atl_step.sv
sv/atl_result_reg.sv
sv/assembly_line_tokenizer_unit.sv
sv/atl_checker.sv
tb/sv/tb.sv
